@@ hw/rtl/ifwt_pkg.sv @@
// ----------------------------------------------------------------------------
// ifwt_pkg
// Shared types and constants of the in-flight frame window tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ifwt_pkg;

    localparam int MAX_FRAMES_DEF  = 8;
    localparam int FRAME_OVERHEAD  = 2 + 2 + 2 + 2;
    localparam int BUDGET_RESET    = 2048;
    localparam int LEN_W           = 12;
    localparam int BUDGET_W        = 16;
    localparam int REPORT_W        = 17;
    localparam int REPORT_MAX      = 131071;

    typedef enum logic [2:0] {
        OP_QUERY   = 3'd0,
        OP_COMMIT  = 3'd1,
        OP_ACK     = 3'd2,
        OP_ERROR   = 3'd3,
        OP_TIMEOUT = 3'd4,
        OP_CLEAR   = 3'd5
    } ifwt_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_READ,
        ST_POP,
        ST_DONE
    } ifwt_state_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] length;
    } ifwt_in_t;

    typedef struct packed {
        logic        may_send;
        logic        rejected;
        logic [3:0]  window_frames;
        logic [16:0] window_bytes;
        logic [31:0] frames_sent;
        logic [31:0] ack_total;
        logic [31:0] error_total;
        logic [31:0] timeout_total;
        logic [31:0] forgotten_total;
        logic [16:0] peak_bytes;
    } ifwt_out_t;

    typedef struct packed {
        logic load;
        logic commit;
        logic reject;
        logic cnt_ack;
        logic cnt_err;
        logic cnt_tmo;
        logic clear;
        logic pop;
        logic forget;
    } ifwt_cmd_t;

    typedef struct packed {
        ifwt_op_t op;
        logic     empty;
        logic     full;
        logic     fits;
    } ifwt_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/ifwt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ifwt_ctrl
// Sequencer: decodes the held item and steps the datapath through pops.
// ----------------------------------------------------------------------------
`default_nettype none

module ifwt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire ifwt_pkg::ifwt_status_t status,
    output ifwt_pkg::ifwt_cmd_t        cmd,
    output logic                       busy,
    output logic                       done
);

    ifwt_pkg::ifwt_state_t state_reg;
    ifwt_pkg::ifwt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ifwt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ifwt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ifwt_pkg::ST_EXEC;
                end
            end
            ifwt_pkg::ST_EXEC:
            begin
                unique case (status.op) inside
                    ifwt_pkg::OP_ACK, ifwt_pkg::OP_ERROR:
                    begin
                        state_next = status.empty ? ifwt_pkg::ST_DONE : ifwt_pkg::ST_READ;
                    end
                    ifwt_pkg::OP_TIMEOUT:
                    begin
                        state_next = ifwt_pkg::ST_CHECK;
                    end
                    default:
                    begin
                        state_next = ifwt_pkg::ST_DONE;
                    end
                endcase
            end
            ifwt_pkg::ST_CHECK:
            begin
                if (!status.empty && !status.fits)
                begin
                    state_next = ifwt_pkg::ST_READ;
                end
                else
                begin
                    state_next = ifwt_pkg::ST_DONE;
                end
            end
            ifwt_pkg::ST_READ:
            begin
                state_next = ifwt_pkg::ST_POP;
            end
            ifwt_pkg::ST_POP:
            begin
                if (status.op == ifwt_pkg::OP_TIMEOUT)
                begin
                    state_next = ifwt_pkg::ST_CHECK;
                end
                else
                begin
                    state_next = ifwt_pkg::ST_DONE;
                end
            end
            ifwt_pkg::ST_DONE:
            begin
                state_next = ifwt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ifwt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ifwt_pkg::ST_IDLE);
        done = (state_reg == ifwt_pkg::ST_DONE);
        unique case (state_reg)
            ifwt_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            ifwt_pkg::ST_EXEC:
            begin
                unique case (status.op)
                    ifwt_pkg::OP_COMMIT:
                    begin
                        cmd.commit = !status.full;
                        cmd.reject = status.full;
                    end
                    ifwt_pkg::OP_ACK:     cmd.cnt_ack = 1'b1;
                    ifwt_pkg::OP_ERROR:   cmd.cnt_err = 1'b1;
                    ifwt_pkg::OP_TIMEOUT: cmd.cnt_tmo = 1'b1;
                    ifwt_pkg::OP_CLEAR:   cmd.clear   = 1'b1;
                    default:
                    begin
                    end
                endcase
            end
            ifwt_pkg::ST_POP:
            begin
                cmd.pop    = 1'b1;
                cmd.forget = (status.op == ifwt_pkg::OP_TIMEOUT);
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTH
    // An accepted item always leaves the controller busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the controller busy");

    // A pop always follows the cycle that fetched the oldest length.
    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ifwt_pkg::ST_POP) |-> ($past(state_reg) == ifwt_pkg::ST_READ))
        else $error("pop without a preceding ring read");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ifwt_datapath.sv @@
// ----------------------------------------------------------------------------
// ifwt_datapath
// Length ring, byte sum, frame count, statistics counters and budget register.
// ----------------------------------------------------------------------------
`default_nettype none

module ifwt_datapath #(
    parameter int MAX_FRAMES = ifwt_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ifwt_pkg::ifwt_in_t    item,
    input  wire ifwt_pkg::ifwt_cmd_t   cmd,
    input  wire logic                  budget_we,
    input  wire logic [15:0]           budget_wdata,
    output ifwt_pkg::ifwt_status_t     status,
    output ifwt_pkg::ifwt_out_t        result
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int TW    = CNT_W + 1;
    localparam int SUM_W = $clog2(MAX_FRAMES * 4095 + 1);
    localparam int FW    = ((SUM_W > ifwt_pkg::BUDGET_W) ? SUM_W : ifwt_pkg::BUDGET_W) + 2;
    localparam int XW    = SUM_W + ifwt_pkg::REPORT_W;

    logic [2:0]                  op_reg;
    logic [ifwt_pkg::LEN_W-1:0]  len_reg;
    logic                        rej_reg, rej_next;
    logic [15:0]                 budget_reg;
    logic [IDX_W-1:0]            head_reg, head_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [SUM_W-1:0]            peak_reg, peak_next;
    logic [31:0]                 sent_reg, sent_next;
    logic [31:0]                 ack_reg, ack_next;
    logic [31:0]                 err_reg, err_next;
    logic [31:0]                 tmo_reg, tmo_next;
    logic [31:0]                 forgot_reg, forgot_next;

    logic [ifwt_pkg::LEN_W-1:0]  ring_mem [MAX_FRAMES];
    logic [ifwt_pkg::LEN_W-1:0]  ring_rd_reg;

    logic [TW-1:0]               tail_sum;
    logic [IDX_W-1:0]            tail_idx;
    logic [SUM_W-1:0]            sum_add;
    logic [FW-1:0]               need;
    logic                        fits;
    logic                        full;
    logic [CNT_W+3:0]            cnt_ext;
    logic [XW-1:0]               sum_ext, peak_ext;

    // Write slot is (head + count) mod depth; count stays below depth on a commit.
    always_comb
    begin
        tail_sum = TW'(head_reg) + TW'(count_reg);
        if (tail_sum >= TW'(MAX_FRAMES))
        begin
            tail_sum = tail_sum - TW'(MAX_FRAMES);
        end
        tail_idx = tail_sum[IDX_W-1:0];
    end

    assign full    = (count_reg >= CNT_W'(MAX_FRAMES));
    assign sum_add = sum_reg + SUM_W'(len_reg);
    assign need    = FW'(sum_reg) + FW'(len_reg) + FW'(ifwt_pkg::FRAME_OVERHEAD);
    assign fits    = !full && (need <= FW'(budget_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            ring_mem[tail_idx] <= len_reg;
        end
        ring_rd_reg <= ring_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= item.opcode;
            len_reg <= item.length;
        end
    end

    always_comb
    begin
        rej_next    = rej_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        peak_next   = peak_reg;
        sent_next   = sent_reg;
        ack_next    = ack_reg;
        err_next    = err_reg;
        tmo_next    = tmo_reg;
        forgot_next = forgot_reg;

        if (cmd.load)
        begin
            rej_next = 1'b0;
        end
        if (cmd.reject)
        begin
            rej_next = 1'b1;
        end
        if (cmd.commit)
        begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_add;
            sent_next  = sent_reg + 32'd1;
            if (sum_add > peak_reg)
            begin
                peak_next = sum_add;
            end
        end
        if (cmd.cnt_ack)
        begin
            ack_next = ack_reg + 32'd1;
        end
        if (cmd.cnt_err)
        begin
            err_next = err_reg + 32'd1;
        end
        if (cmd.cnt_tmo)
        begin
            tmo_next = tmo_reg + 32'd1;
        end
        if (cmd.clear)
        begin
            head_next  = '0;
            count_next = '0;
            sum_next   = '0;
        end
        if (cmd.pop)
        begin
            sum_next   = sum_reg - SUM_W'(ring_rd_reg);
            count_next = count_reg - CNT_W'(1);
            head_next  = (head_reg == IDX_W'(MAX_FRAMES - 1)) ? '0 : head_reg + IDX_W'(1);
        end
        if (cmd.forget)
        begin
            forgot_next = forgot_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rej_reg    <= 1'b0;
            budget_reg <= 16'(ifwt_pkg::BUDGET_RESET);
            head_reg   <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            peak_reg   <= '0;
            sent_reg   <= '0;
            ack_reg    <= '0;
            err_reg    <= '0;
            tmo_reg    <= '0;
            forgot_reg <= '0;
        end
        else
        begin
            if (budget_we)
            begin
                budget_reg <= budget_wdata;
            end
            rej_reg    <= rej_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            peak_reg   <= peak_next;
            sent_reg   <= sent_next;
            ack_reg    <= ack_next;
            err_reg    <= err_next;
            tmo_reg    <= tmo_next;
            forgot_reg <= forgot_next;
        end
    end

    assign status.op    = ifwt_pkg::ifwt_op_t'(op_reg);
    assign status.empty = (count_reg == '0);
    assign status.full  = full;
    assign status.fits  = fits;

    // Byte sums are kept exact and only saturated on the way out.
    assign cnt_ext  = {4'b0, count_reg};
    assign sum_ext  = {{ifwt_pkg::REPORT_W{1'b0}}, sum_reg};
    assign peak_ext = {{ifwt_pkg::REPORT_W{1'b0}}, peak_reg};

    always_comb
    begin
        result.may_send         = fits && ((op_reg == ifwt_pkg::OP_QUERY) ||
                                           (op_reg == ifwt_pkg::OP_TIMEOUT));
        result.rejected         = rej_reg;
        result.window_frames    = cnt_ext[3:0];
        result.window_bytes     = (sum_ext > XW'(ifwt_pkg::REPORT_MAX)) ?
                                  17'(ifwt_pkg::REPORT_MAX) : sum_ext[16:0];
        result.frames_sent      = sent_reg;
        result.ack_total        = ack_reg;
        result.error_total      = err_reg;
        result.timeout_total    = tmo_reg;
        result.forgotten_total  = forgot_reg;
        result.peak_bytes       = (peak_ext > XW'(ifwt_pkg::REPORT_MAX)) ?
                                  17'(ifwt_pkg::REPORT_MAX) : peak_ext[16:0];
    end

`ifndef SYNTH
    // The controller never pops an empty window.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("pop issued on an empty window");

    // A stored commit grows the window by exactly one frame.
    a_commit_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("commit did not add one frame");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/inflight_frame_window_tracker_core.sv @@
// ----------------------------------------------------------------------------
// inflight_frame_window_tracker_core: in-flight frame window tracker.
// Steps: load, EXEC, DONE; ack/error that pops adds READ, POP before DONE.
// Timeout: EXEC, CHECK, then READ (one ring read), POP, CHECK per frame popped.
// Throughput: one item at a time; the next start is taken the cycle after done.
// Async active-low reset empties the window, zeroes counters, budget 2048.
// ----------------------------------------------------------------------------
`default_nettype none

module inflight_frame_window_tracker_core #(
    parameter int MAX_FRAMES = ifwt_pkg::MAX_FRAMES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ifwt_pkg::ifwt_in_t item,
    output logic                    busy,
    output logic                    done,
    output ifwt_pkg::ifwt_out_t     result,
    input  wire logic               byte_budget_we,
    input  wire logic [15:0]        byte_budget_wdata
);

    ifwt_pkg::ifwt_cmd_t    cmd;
    ifwt_pkg::ifwt_status_t status;

    ifwt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ifwt_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .budget_we    (byte_budget_we),
        .budget_wdata (byte_budget_wdata),
        .status       (status),
        .result       (result)
    );

endmodule

`default_nettype wire
